FILE: sv/ced_pkg.sv
// Shared types, constants and character classifiers for the escape sequence decoder.
// Depends on nothing; every other file of the block imports it.
package ced_pkg;

	localparam int CH_W      = 21;
	localparam int CP_W      = 32;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW   = 2;
	localparam int FIFO_CW   = FIFO_AW + 1;

	typedef enum logic [1:0] {
		KIND_PLAIN = 2'd0,
		KIND_ESC   = 2'd1,
		KIND_ERR   = 2'd2
	} kind_t;

	typedef enum logic [6:0] {
		PH_IDLE = 7'b0000001,
		PH_ESC  = 7'b0000010,
		PH_OCT  = 7'b0000100,
		PH_HEX0 = 7'b0001000,
		PH_HEX  = 7'b0010000,
		PH_UNI4 = 7'b0100000,
		PH_UNI8 = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		kind_t           kind;
		logic            last;
	} result_t;

	// Up to two results leave the decoder for one character.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} step_res_t;

	localparam logic [CH_W-1:0] CH_BSLASH = 21'h5C;
	localparam logic [CH_W-1:0] CH_ZERO   = 21'h30;
	localparam logic [CH_W-1:0] CH_SEVEN  = 21'h37;
	localparam logic [CH_W-1:0] CH_HEX_X  = 21'h78;
	localparam logic [CH_W-1:0] CH_UNI_LO = 21'h75;
	localparam logic [CH_W-1:0] CH_UNI_UP = 21'h55;
	localparam logic [7:0]      ESC_CODE  = 8'h1B;

	// Returns {valid, value} for a hexadecimal digit character.
	function automatic logic [4:0] hex_digit(input logic [CH_W-1:0] c);
		logic dec;
		logic low;
		logic up;
		dec = (c >= 21'h30) && (c <= 21'h39);
		low = (c >= 21'h61) && (c <= 21'h66);
		up  = (c >= 21'h41) && (c <= 21'h46);
		if (dec) begin
			return {1'b1, c[3:0]};
		end else if (low || up) begin
			return {1'b1, c[3:0] + 4'd9};
		end
		return 5'd0;
	endfunction

	// Returns {hit, value} for the single-character escapes.
	function automatic logic [8:0] simple_escape(input logic [CH_W-1:0] c);
		logic [8:0] r;
		unique case (c)
			21'h27: r = {1'b1, 8'h27};
			21'h22: r = {1'b1, 8'h22};
			21'h3F: r = {1'b1, 8'h3F};
			21'h5C: r = {1'b1, 8'h5C};
			21'h61: r = {1'b1, 8'h07};
			21'h62: r = {1'b1, 8'h08};
			21'h66: r = {1'b1, 8'h0C};
			21'h6E: r = {1'b1, 8'h0A};
			21'h72: r = {1'b1, 8'h0D};
			21'h74: r = {1'b1, 8'h09};
			21'h76: r = {1'b1, 8'h0B};
			21'h65: r = {1'b1, ESC_CODE};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/ced_if.sv
// Valid/ready channel interfaces for the characters in and the decoded results out.
// Depends on ced_pkg for field widths and the result kind type.
interface ced_char_if;
	import ced_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;
	logic            in_last;
	modport source (output valid, ch, in_last, input ready);
	modport sink (input valid, ch, in_last, output ready);
endinterface

interface ced_result_if;
	import ced_pkg::*;
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] code_point;
	kind_t           kind;
	logic            out_last;
	modport source (output valid, code_point, kind, out_last, input ready);
	modport sink (input valid, code_point, kind, out_last, output ready);
endinterface

FILE: sv/ced_step.sv
// Escape decoding state machine: the phase, accumulator and digit count registers
// and the per-character next-state logic. Depends on ced_pkg.
module ced_step (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [ced_pkg::CH_W-1:0] ch,
	input  logic                     last,
	output ced_pkg::step_res_t       res
);
	import ced_pkg::*;

	phase_t          phase_q, phase_d;
	logic [CP_W-1:0] acc_q, acc_d;
	logic [3:0]      dig_q, dig_d;
	logic            skip_q, skip_d;

	logic [4:0] hx;
	logic [8:0] se;
	logic       is_oct;
	logic [3:0] dig_inc;
	logic [3:0] need;
	logic       idle_go;
	logic       idle_slot;
	logic       err;
	logic       err_slot;
	step_res_t  r;

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		dig_d     = dig_q;
		skip_d    = skip_q;
		r         = '0;
		idle_go   = 1'b0;
		idle_slot = 1'b0;
		err       = 1'b0;
		err_slot  = 1'b0;
		hx        = hex_digit(ch);
		se        = simple_escape(ch);
		is_oct    = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
		dig_inc   = dig_q + 4'd1;
		need      = (phase_q == PH_UNI4) ? 4'd4 : 4'd8;

		if (!skip_q) begin
			unique case (phase_q) inside
				PH_ESC: begin
					phase_d = PH_IDLE;
					if (se[8]) begin
						r.first = '{code_point: {24'd0, se[7:0]}, kind: KIND_ESC, last: last};
						r.count = 2'd1;
					end else if (is_oct) begin
						acc_d   = {29'd0, ch[2:0]};
						dig_d   = 4'd1;
						phase_d = PH_OCT;
						if (last) begin
							r.first = '{code_point: {29'd0, ch[2:0]}, kind: KIND_ESC, last: 1'b1};
							r.count = 2'd1;
						end
					end else if (ch == CH_HEX_X || ch == CH_UNI_LO || ch == CH_UNI_UP) begin
						acc_d   = '0;
						dig_d   = 4'd0;
						phase_d = (ch == CH_HEX_X) ? PH_HEX0 :
							(ch == CH_UNI_LO) ? PH_UNI4 : PH_UNI8;
						err     = last;
					end else begin
						r.first = '{code_point: {11'd0, ch}, kind: KIND_ESC, last: last};
						r.count = 2'd1;
					end
				end
				PH_OCT: begin
					if (is_oct) begin
						acc_d = {acc_q[CP_W-4:0], ch[2:0]};
						dig_d = dig_inc;
						if (dig_inc >= 4'd3 || last) begin
							r.first = '{code_point: {acc_q[CP_W-4:0], ch[2:0]},
								kind: KIND_ESC, last: last};
							r.count = 2'd1;
							phase_d = PH_IDLE;
						end
					end else begin
						r.first   = '{code_point: acc_q, kind: KIND_ESC, last: 1'b0};
						r.count   = 2'd1;
						phase_d   = PH_IDLE;
						idle_go   = 1'b1;
						idle_slot = 1'b1;
					end
				end
				PH_HEX0, PH_HEX: begin
					if (hx[4]) begin
						acc_d   = {acc_q[CP_W-5:0], hx[3:0]};
						phase_d = PH_HEX;
						if (last) begin
							r.first = '{code_point: {acc_q[CP_W-5:0], hx[3:0]},
								kind: KIND_ESC, last: 1'b1};
							r.count = 2'd1;
						end
					end else if (phase_q == PH_HEX0) begin
						err = 1'b1;
					end else begin
						r.first   = '{code_point: acc_q, kind: KIND_ESC, last: 1'b0};
						r.count   = 2'd1;
						phase_d   = PH_IDLE;
						idle_go   = 1'b1;
						idle_slot = 1'b1;
					end
				end
				PH_UNI4, PH_UNI8: begin
					if (!hx[4]) begin
						err = 1'b1;
					end else begin
						acc_d = {acc_q[CP_W-5:0], hx[3:0]};
						dig_d = dig_inc;
						if (dig_inc >= need) begin
							r.first = '{code_point: {acc_q[CP_W-5:0], hx[3:0]},
								kind: KIND_ESC, last: last};
							r.count = 2'd1;
							phase_d = PH_IDLE;
						end else begin
							err = last;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
					idle_go = 1'b1;
				end
			endcase

			// A character handled outside any escape, possibly right after a
			// run that it ended.
			if (idle_go) begin
				if (ch == CH_BSLASH) begin
					if (last) begin
						err      = 1'b1;
						err_slot = idle_slot;
					end else begin
						phase_d = PH_ESC;
					end
				end else if (idle_slot) begin
					r.second = '{code_point: {11'd0, ch}, kind: KIND_PLAIN, last: last};
					r.count  = 2'd2;
				end else begin
					r.first = '{code_point: {11'd0, ch}, kind: KIND_PLAIN, last: last};
					r.count = 2'd1;
				end
			end

			if (err) begin
				if (err_slot) begin
					r.second = '{code_point: '0, kind: KIND_ERR, last: last};
					r.count  = 2'd2;
				end else begin
					r.first = '{code_point: '0, kind: KIND_ERR, last: last};
					r.count = 2'd1;
				end
				phase_d = PH_IDLE;
				acc_d   = '0;
				dig_d   = 4'd0;
				skip_d  = !last;
			end
		end

		// The end of the literal returns every register to its reset value.
		if (last) begin
			phase_d = PH_IDLE;
			acc_d   = '0;
			dig_d   = 4'd0;
			skip_d  = 1'b0;
		end

		if (!en) begin
			r.count = 2'd0;
		end
	end

	assign res = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			dig_q   <= 4'd0;
			skip_q  <= 1'b0;
		end else if (en) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			dig_q   <= dig_d;
			skip_q  <= skip_d;
		end
	end

endmodule

FILE: sv/ced_result_fifo.sv
// Four-entry result queue that takes up to two results per cycle and gives one.
// Depends on ced_pkg for the result types and queue sizes.
module ced_result_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  ced_pkg::step_res_t push,
	input  logic               pop,
	output ced_pkg::result_t   head,
	output logic               not_empty,
	output logic               room2
);
	import ced_pkg::*;

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q;
	logic [FIFO_AW-1:0]   rd_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 do_pop;

	assign not_empty = (count_q != '0);
	assign room2     = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_q + FIFO_AW'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FIFO_AW'(push.count);
			rd_q    <= rd_q + FIFO_AW'(do_pop);
			count_q <= count_q + FIFO_CW'(push.count) - FIFO_CW'(do_pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |-> (count_q + FIFO_CW'(push.count) <= FIFO_CW'(FIFO_DEPTH)))
		else $error("result queue pushed past its depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_q - rd_q) == count_q[FIFO_AW-1:0])
		else $error("result queue pointers disagree with count");

endmodule

FILE: sv/c_escape_sequence_decoder.sv
// Path: a character taken into the input stage is decoded and written to the result queue.
// Throughput: one character per cycle while results are taken; a character with two
// results leaves one extra entry in the four-entry result queue, which absorbs it.
// Reset: arst_n clears the input stage, the escape state machine and the queue.
// Depends on ced_pkg, ced_if, ced_step and ced_result_fifo.
module c_escape_sequence_decoder (
	input  logic        clk,
	input  logic        arst_n,
	ced_char_if.sink    chars,
	ced_result_if.source results
);
	import ced_pkg::*;

	// Input stage. A character waits here until the result queue has room for
	// the two results that it may cause; it is then decoded combinationally against
	// the current escape state and its results are written to the queue.
	logic            valid_s1;
	logic [CH_W-1:0] ch_s1;
	logic            last_s1;
	logic            advance;
	logic            load;

	step_res_t step_res;
	result_t   head;
	logic      not_empty;
	logic      room2;

	// The queue's room is taken from its registered count, so ready on the
	// character side never depends on ready on the result side in the same cycle.
	assign advance     = valid_s1 && room2;
	assign chars.ready = !valid_s1 || advance;
	assign load        = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ch_s1   <= chars.ch;
			last_s1 <= chars.in_last;
		end
	end

	// The decoder updates its state only for a character that advances, so a
	// stalled character is decoded exactly once.
	ced_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.ch     (ch_s1),
		.last   (last_s1),
		.res    (step_res)
	);

	// Results leave the head of the queue one per cycle while results.ready is high.
	ced_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step_res),
		.pop       (results.ready),
		.head      (head),
		.not_empty (not_empty),
		.room2     (room2)
	);

	assign results.valid      = not_empty;
	assign results.code_point = head.code_point;
	assign results.kind       = head.kind;
	assign results.out_last   = head.last;

endmodule

FILE: tb/c_escape_sequence_decoder_test.sv
// Self-checking testbench for the C escape sequence decoder: random and directed literals.
// Depends on ced_pkg, ced_if and the c_escape_sequence_decoder RTL.
`timescale 1ns / 1ps

module c_escape_sequence_decoder_test;
	import ced_pkg::*;

	// The slowest legal run stays far below this many cycles, even with long stalls.
	localparam int CYCLE_LIMIT = 400000;
	// Least number of characters sent in total, the directed ones included.
	localparam int CHAR_TARGET = 440;
	// Once this many characters are in, the result side holds off for a long stretch.
	localparam int HOLD_AFTER  = 120;
	localparam int HOLD_CYCLES = 200;
	// Cycles to watch for stray results after the last expected one.
	localparam int DRAIN_CYCLES = 16;

	// Tracks the decoder state from accepted characters and keeps the decoded code points
	// that are still due on the result channel.
	class escape_decode_tracker;
		phase_t        phase;
		logic [31:0]   acc;
		logic [3:0]    ndig;
		bit            skip;
		result_t       due_points[$];
		int            errors;

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			phase = PH_IDLE;
			acc   = '0;
			ndig  = '0;
			skip  = 1'b0;
		endfunction

		function void put(logic [31:0] cp, kind_t k, logic l);
			result_t r;
			r.code_point = cp;
			r.kind       = k;
			r.last       = l;
			due_points.push_back(r);
		endfunction

		function int hex_of(logic [CH_W-1:0] c);
			if (c >= "0" && c <= "9") begin
				return int'(c - "0");
			end
			if (c >= "a" && c <= "f") begin
				return int'(c - "a") + 10;
			end
			if (c >= "A" && c <= "F") begin
				return int'(c - "A") + 10;
			end
			return -1;
		endfunction

		// A malformed escape gives one error result; the rest of the literal is dropped
		// unless the error came on its final character.
		function void raise_error(logic l);
			put('0, KIND_ERR, l);
			clear();
			skip = !l;
		endfunction

		// A character seen while no escape is open: a backslash opens one, anything
		// else passes through as a plain character.
		function void outside_escape(logic [CH_W-1:0] c, logic l);
			if (c == CH_BSLASH) begin
				if (l) begin
					raise_error(l);
				end else begin
					phase = PH_ESC;
				end
			end else begin
				put(32'(c), KIND_PLAIN, l);
			end
		endfunction

		function void universal_digit(logic [CH_W-1:0] c, logic l, int need);
			int h;
			h = hex_of(c);
			if (h < 0) begin
				raise_error(l);
				return;
			end
			acc  = (acc << 4) | 32'(h);
			ndig = ndig + 4'd1;
			if (int'(ndig) >= need) begin
				put(acc, KIND_ESC, l);
				phase = PH_IDLE;
			end else if (l) begin
				raise_error(l);
			end
		endfunction

		function void note_char(logic [CH_W-1:0] c, logic l);
			int          h;
			logic [31:0] v;
			bit          hit;
			if (!skip) begin
				case (phase)
					PH_ESC: begin
						phase = PH_IDLE;
						hit   = 1'b1;
						v     = '0;
						case (c)
							"'":     v = 32'h27;
							"\"":    v = 32'h22;
							"?":     v = 32'h3F;
							"\\":    v = 32'h5C;
							"a":     v = 32'h07;
							"b":     v = 32'h08;
							"f":     v = 32'h0C;
							"n":     v = 32'h0A;
							"r":     v = 32'h0D;
							"t":     v = 32'h09;
							"v":     v = 32'h0B;
							"e":     v = 32'(ESC_CODE);
							default: hit = 1'b0;
						endcase
						if (hit) begin
							put(v, KIND_ESC, l);
						end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
							acc   = 32'(c - CH_ZERO);
							ndig  = 4'd1;
							phase = PH_OCT;
							if (l) begin
								put(acc, KIND_ESC, l);
							end
						end else if (c == CH_HEX_X || c == CH_UNI_LO || c == CH_UNI_UP) begin
							acc  = '0;
							ndig = '0;
							if (c == CH_HEX_X) begin
								phase = PH_HEX0;
							end else if (c == CH_UNI_LO) begin
								phase = PH_UNI4;
							end else begin
								phase = PH_UNI8;
							end
							if (l) begin
								raise_error(l);
							end
						end else begin
							// Unknown escape: the character itself.
							put(32'(c), KIND_ESC, l);
						end
					end
					PH_OCT: begin
						if (c >= CH_ZERO && c <= CH_SEVEN) begin
							acc  = (acc << 3) | 32'(c - CH_ZERO);
							ndig = ndig + 4'd1;
							if (ndig >= 4'd3 || l) begin
								put(acc, KIND_ESC, l);
								phase = PH_IDLE;
							end
						end else begin
							put(acc, KIND_ESC, 1'b0);
							phase = PH_IDLE;
							outside_escape(c, l);
						end
					end
					PH_HEX0, PH_HEX: begin
						h = hex_of(c);
						if (h >= 0) begin
							acc   = (acc << 4) + 32'(h);
							phase = PH_HEX;
							if (l) begin
								put(acc, KIND_ESC, l);
							end
						end else if (phase == PH_HEX0) begin
							raise_error(l);
						end else begin
							put(acc, KIND_ESC, 1'b0);
							phase = PH_IDLE;
							outside_escape(c, l);
						end
					end
					PH_UNI4: universal_digit(c, l, 4);
					PH_UNI8: universal_digit(c, l, 8);
					default: begin
						phase = PH_IDLE;
						outside_escape(c, l);
					end
				endcase
			end
			// Every literal starts from a clean state.
			if (l) begin
				clear();
			end
		endfunction

		function void check_result(logic [31:0] cp, kind_t k, logic l);
			result_t want;
			if (due_points.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected result: cp=%h kind=%0d last=%0b", cp, k, l);
				end
				return;
			end
			want = due_points.pop_front();
			if (cp !== want.code_point || k !== want.kind || l !== want.last) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: expected cp=%h kind=%0d last=%0b, got cp=%h kind=%0d last=%0b",
						want.code_point, want.kind, want.last, cp, k, l);
				end
			end
		endfunction

		function void check_leftovers();
			if (due_points.size() != 0) begin
				errors += due_points.size();
				$display("%0d expected results never arrived", due_points.size());
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ced_char_if   chars_if();
	ced_result_if results_if();

	c_escape_sequence_decoder DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (results_if)
	);

	escape_decode_tracker decoder_state = new();

	// Characters of the literal being assembled, sent as one burst with in_last on the end.
	logic [CH_W-1:0] lit_q[$];
	int              chars_taken = 0;
	int              cycles = 0;
	bit              quiet_sender = 1'b0;

	string simple_set = "'\"?\\abfnrtve";
	string hex_set    = "0123456789abcdefABCDEF";
	string odd_set    = "89gzq %";

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Reset is asserted from time zero and released on a falling edge, away from sampling.
	initial begin
		arst_n = 1'b0;
		chars_if.valid   = 1'b0;
		chars_if.ch      = '0;
		chars_if.in_last = 1'b0;
		results_if.ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Mostly no gap or a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Offers one character from a falling edge and returns at the rising edge that takes it.
	// The valid line stays high between back-to-back transactions.
	task automatic send_char(logic [CH_W-1:0] c, logic l);
		int gap;
		gap = quiet_sender ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		chars_if.valid   <= 1'b1;
		chars_if.ch      <= c;
		chars_if.in_last <= l;
		do begin
			@(posedge clk);
		end while (!chars_if.ready);
		decoder_state.note_char(c, l);
		chars_taken++;
	endtask

	task automatic send_literal();
		foreach (lit_q[i]) begin
			send_char(lit_q[i], i == lit_q.size() - 1);
		end
		lit_q.delete();
	endtask

	task automatic push_str(string s);
		foreach (s[i]) begin
			lit_q.push_back(CH_W'(s[i]));
		end
	endtask

	function automatic logic [CH_W-1:0] rand_plain();
		logic [CH_W-1:0] c;
		case ($urandom_range(0, 3))
			0, 1: begin
				c = CH_W'($urandom_range(32'h20, 32'h7E));
				if (c == CH_BSLASH) begin
					c = CH_W'("_");
				end
			end
			2:       c = CH_W'($urandom);
			default: c = CH_W'($urandom_range(0, 32'h10FFFF));
		endcase
		return c;
	endfunction

	function automatic logic [CH_W-1:0] rand_hex();
		return CH_W'(hex_set[$urandom_range(0, 21)]);
	endfunction

	// Appends one piece of a literal: mostly well-formed escapes and plain characters,
	// with some broken escapes and noise mixed in.
	task automatic add_segment();
		int need;
		case ($urandom_range(0, 11))
			0, 1, 2: lit_q.push_back(rand_plain());
			3: begin
				push_str("\\");
				lit_q.push_back(CH_W'(simple_set[$urandom_range(0, 11)]));
			end
			4: begin
				push_str("\\");
				repeat ($urandom_range(1, 3)) lit_q.push_back(CH_ZERO + CH_W'($urandom_range(0, 7)));
			end
			5: begin
				push_str("\\x");
				repeat ($urandom_range(1, 10)) lit_q.push_back(rand_hex());
			end
			6: begin
				push_str("\\u");
				repeat (4) lit_q.push_back(rand_hex());
			end
			7: begin
				push_str("\\U");
				repeat (8) lit_q.push_back(rand_hex());
			end
			8: begin
				push_str("\\");
				if ($urandom_range(0, 1) == 0) begin
					lit_q.push_back(CH_W'(odd_set[$urandom_range(0, 6)]));
				end else begin
					lit_q.push_back(rand_plain());
				end
			end
			9: begin
				// Hex escape with no digit at all.
				push_str("\\x");
				lit_q.push_back(CH_W'(odd_set[$urandom_range(2, 6)]));
			end
			10: begin
				// Universal character cut short by a non-hex character.
				if ($urandom_range(0, 1) == 0) begin
					push_str("\\u");
					need = 4;
				end else begin
					push_str("\\U");
					need = 8;
				end
				repeat ($urandom_range(0, need - 1)) lit_q.push_back(rand_hex());
				push_str("G");
			end
			default: begin
				push_str("\\");
				lit_q.push_back(CH_W'($urandom));
			end
		endcase
	endtask

	// Result side: bursts of ready with random gaps, plus one long hold-off once the
	// input side is well under way, so the result queue fills and the input stalls.
	initial begin
		bit held;
		int run;
		int gap;
		held = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held && chars_taken >= HOLD_AFTER) begin
				held = 1'b1;
				results_if.ready <= 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++) begin
					@(negedge clk);
				end
			end
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			results_if.ready <= 1'b1;
			repeat (run) @(negedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				results_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	end

	// Every result transaction is checked at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready) begin
			decoder_state.check_result(results_if.code_point, results_if.kind,
				results_if.out_last);
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[c_escape_sequence_decoder] ERROR");
		$finish;
	end

	initial begin
		int cut;
		@(posedge arst_n);

		// Directed part. The first literal covers the widest character, the escape
		// character escape, a full three-digit octal escape, a hex run long enough to
		// wrap 32 bits that is ended by a backslash, a four-digit universal character
		// and a plain character carrying in_last.
		lit_q.push_back({CH_W{1'b1}});
		push_str("\\e\\777\\x123456789\\u0041A");
		send_literal();
		// Zero character, then an octal run ended by a plain character on the last slot.
		lit_q.push_back('0);
		push_str("\\1z");
		send_literal();
		// Trailing backslash.
		push_str("\\");
		send_literal();
		// Missing hex digit in the middle of a literal, then the skipped remainder.
		push_str("\\xg\\n7");
		send_literal();

		// Random literals until the character budget is used up.
		while (chars_taken < CHAR_TARGET) begin
			quiet_sender = ($urandom_range(0, 7) == 0);
			repeat ($urandom_range(1, 6)) add_segment();
			// Some literals end in the middle of an escape.
			if ($urandom_range(0, 9) == 0 && lit_q.size() > 1) begin
				cut = $urandom_range(1, lit_q.size() - 1);
				repeat (cut) void'(lit_q.pop_back());
			end
			send_literal();
		end
		quiet_sender = 1'b0;

		@(negedge clk);
		chars_if.valid <= 1'b0;

		// Wait for the outstanding results, then watch a little longer for strays.
		while (decoder_state.due_points.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		decoder_state.check_leftovers();

		if (decoder_state.errors == 0) begin
			$display("[c_escape_sequence_decoder] OK");
		end else begin
			$display("[c_escape_sequence_decoder] ERROR");
		end
		$finish;
	end

endmodule
